// ===== rtl/vt4x4_pkg.sv =====
// vertex transform package: fixed-point widths, types and matrix reset values
// used by vertex_transform_4x4_core; depends on nothing
package vt4x4_pkg;

  // fixed-point format of vector, matrix and result words
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int DIM        = 4;

  // growth through the product and the two adder levels
  localparam int PROD_W     = 2 * DATA_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int SHIFT_W    = SUM_W - FRAC_BITS;

  // configuration space: two matrix elements per 64-bit register
  localparam int NUM_PAIRS  = (DIM * DIM) / 2;
  localparam int CFG_W      = 2 * DATA_W;
  localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);
  localparam int BYTE_OFS_W = $clog2(CFG_W / 8);
  localparam int ADDR_W     = PAIR_IDX_W + BYTE_OFS_W;

  typedef logic signed [DATA_W-1:0]  word_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PAIR_W-1:0]  pair_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [SHIFT_W-1:0] shift_t;
  typedef logic [CFG_W-1:0]          cfg_word_t;

  localparam word_t ONE_VAL = word_t'(64'd1 << FRAC_BITS);
  localparam word_t MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  // identity matrix: element e is on the diagonal when its row equals its column
  function automatic cfg_word_t pair_reset(input logic [PAIR_IDX_W-1:0] pair);
    logic [PAIR_IDX_W:0] e_lo;
    logic [PAIR_IDX_W:0] e_hi;
    cfg_word_t           val;
    e_lo = {pair, 1'b0};
    e_hi = {pair, 1'b1};
    val  = '0;
    if (e_lo[1:0] == e_lo[3:2]) begin
      val[DATA_W-1:0] = ONE_VAL;
    end
    if (e_hi[1:0] == e_hi[3:2]) begin
      val[CFG_W-1:DATA_W] = ONE_VAL;
    end
    return val;
  endfunction

endpackage

// ===== rtl/vertex_transform_4x4_core.sv =====
// vertex transform top level: 4x4 fixed-point matrix times vector, three-stage pipeline
// depends on vt4x4_pkg
//
// usage:
//   input channel in_valid/in_ready carries one vector (in_x..in_w, signed Q16.16)
//   per request; output channel out_valid/out_ready returns out_x..out_w, the
//   matrix rows dotted with the vector, plus the saturated flag.
//   the matrix sits in eight 64-bit APB registers at byte address 8*k, column
//   major, element 2k in bits 31:0 and element 2k+1 in bits 63:32; reads return
//   the register value. the user must make writes only while no request is in flight;
//   the block itself does not enforce this.
// pipeline: stage 1 loads at the accepting edge: sixteen 32x32 products,
//   stage 2: pair sums, stage 3: final sum, shift, saturation into the output register.
// throughput: one request per cycle while the output is not stalled, set by the
//   fully parallel multiplier array; every stage carries its own valid bit.
// stall: when out_ready is low the result holds and the earlier stages keep
//   filling; in_ready drops only once all three stages hold a request.
// reset: rst (synchronous) empties the pipeline and loads the identity matrix.
module vertex_transform_4x4_core
  import vt4x4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input vectors
  input  logic              in_valid,
  output logic              in_ready,
  input  word_t             in_x,
  input  word_t             in_y,
  input  word_t             in_z,
  input  word_t             in_w,
  // transformed vectors
  output logic              out_valid,
  input  logic              out_ready,
  output word_t             out_x,
  output word_t             out_y,
  output word_t             out_z,
  output word_t             out_w,
  output logic              saturated,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  cfg_word_t         pwdata,
  output cfg_word_t         prdata,
  output logic              pready
);

  cfg_word_t mat [NUM_PAIRS];

  word_t vec [DIM];
  word_t elem [DIM][DIM];        // [row][column]

  prod_t prod      [DIM][DIM];
  prod_t prod_next [DIM][DIM];
  pair_t psum      [DIM][2];
  pair_t psum_next [DIM][2];

  sum_t   total   [DIM];
  shift_t shifted [DIM];
  word_t  res_next [DIM];
  logic   [DIM-1:0] clamp;

  logic p1_valid;
  logic p2_valid;
  logic out_load;
  logic s2_ready;
  logic s1_ready;
  logic [PAIR_IDX_W-1:0] cfg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:BYTE_OFS_W];
  assign prdata  = mat[cfg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        mat[p] <= pair_reset(PAIR_IDX_W'(p));
      end
    end else if (psel && penable && pwrite && pready) begin
      mat[cfg_idx] <= pwdata;
    end
  end

  // matrix element unpack: element 4*col+row, column major
  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar k = 0; k < DIM; k++) begin : g_col
      localparam int E = DIM * k + r;
      assign elem[r][k] = word_t'(mat[E / 2][(E % 2) * DATA_W +: DATA_W]);
    end
  end

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  // pipeline handshake: a stage loads when it is empty or its successor moves
  assign out_load = !out_valid || out_ready;
  assign s2_ready = !p2_valid || out_load;
  assign s1_ready = !p1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        p1_valid <= in_valid;
      end
      if (s2_ready) begin
        p2_valid <= p1_valid;
      end
      if (out_load) begin
        out_valid <= p2_valid;
      end
    end
  end

  // stage 1: sixteen full-width products
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int k = 0; k < DIM; k++) begin
        prod_next[r][k] = prod_t'(elem[r][k]) * prod_t'(vec[k]);
      end
    end
  end

  // stage 2: sum products in pairs
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int h = 0; h < 2; h++) begin
        psum_next[r][h] = pair_t'(prod[r][2*h]) + pair_t'(prod[r][2*h+1]);
      end
    end
  end

  // stage 3: final sum, arithmetic shift, clamp to 32 bits
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      total[r]   = sum_t'(psum[r][0]) + sum_t'(psum[r][1]);
      shifted[r] = shift_t'(total[r] >>> FRAC_BITS);
      if ((&shifted[r][SHIFT_W-1:DATA_W-1]) || !(|shifted[r][SHIFT_W-1:DATA_W-1])) begin
        res_next[r] = shifted[r][DATA_W-1:0];
        clamp[r]    = 1'b0;
      end else if (shifted[r][SHIFT_W-1]) begin
        res_next[r] = MIN_VAL;
        clamp[r]    = 1'b1;
      end else begin
        res_next[r] = MAX_VAL;
        clamp[r]    = 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      prod <= prod_next;
    end
    if (s2_ready) begin
      psum <= psum_next;
    end
    if (out_load) begin
      out_x     <= res_next[0];
      out_y     <= res_next[1];
      out_z     <= res_next[2];
      out_w     <= res_next[3];
      saturated <= |clamp;
    end
  end

  // an accepted request always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> p1_valid)
    else $error("accepted request did not enter stage 1");

  // a full, stalled pipeline must refuse new requests
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    p1_valid && p2_valid && out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while pipeline full and stalled");

  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !p1_valid && !p2_valid && !out_valid)
    else $error("pipeline not empty after reset");

  // a clamp leaves at least one component at a limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == MAX_VAL || out_x == MIN_VAL || out_y == MAX_VAL || out_y == MIN_VAL ||
       out_z == MAX_VAL || out_z == MIN_VAL || out_w == MAX_VAL || out_w == MIN_VAL))
    else $error("saturated flag without a clamped component");

endmodule
